[rtl/core/telegram_receiver_crc16_check_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the telegram receiver
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TELEGRAM_RECEIVER_CRC16_CHECK_TOP_MACROS_SVH
`define TELEGRAM_RECEIVER_CRC16_CHECK_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TLGRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define TLGRX_ASSERT_NEVER(lbl, cond, msg) \
  `TLGRX_ASSERT(lbl, !(cond), msg)

`endif

[rtl/core/tlgrx_pkg.sv]
// ----------------------------------------------------------------------------
// tlgrx_pkg
// Shared types, constants and the CRC-16 step for the telegram receiver.
// ----------------------------------------------------------------------------
package tlgrx_pkg;

  localparam int unsigned MaxFramePayloadDef = 1024;
  localparam int unsigned CmdQueueDepth      = 2;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 11;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  localparam logic [ByteW-1:0] HdrStx  = 8'h02;
  localparam logic [ByteW-1:0] HdrAddr = 8'h80;
  localparam logic [ByteW-1:0] TypeAck = 8'hA0;
  localparam logic [ByteW-1:0] TypeNak = 8'h92;

  localparam logic [CrcW-1:0] CrcPoly = 16'h8005;
  localparam logic [CrcW-1:0] CrcMask = 16'h7fff;

  localparam logic [CountW-1:0] MaxPayloadRst = 11'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACK_ONLY    = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_LEN_ERR  = 2'd3
  } frame_status_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STATUS  = 2'd2,
    PH_CRC     = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,  // header matched, first payload byte
    CMD_DATA      = 3'd1,  // further payload byte
    CMD_STAT_BYTE = 3'd2,  // status byte, CRC only
    CMD_CHECK     = 3'd3,  // received CRC complete
    CMD_ERROR     = 3'd4   // frame rejected at header
  } cmd_op_e;

  typedef struct packed {
    logic                    ack_only;
    logic [CfgDataW-1:0]     max_payload;
  } cfg_t;

  typedef struct packed {
    cmd_op_e                 op;
    logic [4*ByteW-1:0]      hdr;     // STX, address, length low, length high
    logic [ByteW-1:0]        data;
    logic [CrcW-1:0]         rx_crc;
    logic [CountW-1:0]       count;
    frame_status_e           status;
  } cmd_t;

  // One step of the shift-xor CRC: shift with feedback, then mix in the
  // previous and the current byte.
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0]  crc,
                                               input logic [ByteW-1:0] prev,
                                               input logic [ByteW-1:0] cur);
    logic [CrcW-1:0] sh;
    sh = {crc[CrcW-2:0] & CrcMask[CrcW-2:0], 1'b0};
    if (crc[CrcW-1]) sh = sh ^ CrcPoly;
    return sh ^ {prev, cur};
  endfunction

endpackage

[rtl/core/tlgrx_front.sv]
// ----------------------------------------------------------------------------
// tlgrx_front
// Header hunt and frame sequencing; turns each byte into a back-end command.
// ----------------------------------------------------------------------------
module tlgrx_front import tlgrx_pkg::*; #(
  parameter int unsigned MaxFramePayload = MaxFramePayloadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o
);

  localparam int unsigned LenW       = $clog2(MaxFramePayload + 1);
  localparam logic [15:0] FrameLimit = 16'(MaxFramePayload);

  phase_e               phase_q, phase_d;
  logic [4*ByteW-1:0]   win_q, win_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LenW-1:0]      cnt_q, cnt_d;
  logic [ByteW-1:0]     crc_lo_q, crc_lo_d;
  logic                 lo_seen_q, lo_seen_d;

  logic [15:0]          len_field, len_m1, limit;
  logic [LenW-1:0]      cnt_inc;
  logic                 type_ok, hdr_match;

  // Window holds the four bytes before the current one.
  assign len_field = {win_q[ByteW-1:0], win_q[2*ByteW-1:ByteW]};
  assign len_m1    = len_field - 16'd1;
  assign limit     = (16'(cfg_i.max_payload) < FrameLimit) ? 16'(cfg_i.max_payload)
                                                           : FrameLimit;
  assign cnt_inc   = cnt_q + LenW'(1);
  assign type_ok   = !cfg_i.ack_only || (byte_i == TypeAck) || (byte_i == TypeNak);
  assign hdr_match = (win_q[4*ByteW-1:3*ByteW] == HdrStx) &&
                     (win_q[3*ByteW-1:2*ByteW] == HdrAddr) && type_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      win_q     <= '0;
      cnt_q     <= '0;
      lo_seen_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      win_q     <= win_d;
      cnt_q     <= cnt_d;
      lo_seen_q <= lo_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    crc_lo_q <= crc_lo_d;
  end

  always_comb begin
    phase_d     = phase_q;
    win_d       = win_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    crc_lo_d    = crc_lo_q;
    lo_seen_d   = lo_seen_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.data  = byte_i;
    if (valid_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          win_d = {win_q[3*ByteW-1:0], byte_i};
          if (hdr_match) begin
            win_d       = '0;
            cmd_valid_o = 1'b1;
            if (len_field < 16'd2) begin
              cmd_o.op     = CMD_ERROR;
              cmd_o.status = ST_LEN_ERR;
            end else if (len_m1 > limit) begin
              cmd_o.op     = CMD_ERROR;
              cmd_o.status = ST_OVERFLOW;
            end else begin
              cmd_o.op  = CMD_START;
              cmd_o.hdr = win_q;
              len_d     = len_m1[LenW-1:0];
              cnt_d     = LenW'(1);
              phase_d   = (len_m1 == 16'd1) ? PH_STATUS : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = CMD_DATA;
          cnt_d       = cnt_inc;
          if (cnt_inc >= len_q) phase_d = PH_STATUS;
        end
        PH_STATUS: begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = CMD_STAT_BYTE;
          lo_seen_d   = 1'b0;
          phase_d     = PH_CRC;
        end
        PH_CRC: begin
          if (!lo_seen_q) begin
            crc_lo_d  = byte_i;
            lo_seen_d = 1'b1;
          end else begin
            cmd_valid_o  = 1'b1;
            cmd_o.op     = CMD_CHECK;
            cmd_o.rx_crc = {byte_i, crc_lo_q};
            cmd_o.count  = CountW'(len_q);
            win_d        = '0;
            phase_d      = PH_HUNT;
          end
        end
      endcase
    end
  end

endmodule

[rtl/core/tlgrx_fifo.sv]
// ----------------------------------------------------------------------------
// tlgrx_fifo
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module tlgrx_fifo import tlgrx_pkg::*; #(
  parameter int unsigned Depth = CmdQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/core/tlgrx_back.sv]
// ----------------------------------------------------------------------------
// tlgrx_back
// Runs the CRC, checks the received CRC and drives the result register.
// ----------------------------------------------------------------------------
module tlgrx_back import tlgrx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  output logic              out_valid_o,
  input  logic              out_pop_i,
  output logic              kind_o,
  output logic [ByteW-1:0]  payload_byte_o,
  output logic [1:0]        frame_status_o,
  output logic [CountW-1:0] payload_count_o,
  output logic              last_o
);

  logic [CrcW-1:0]   crc_q, crc_d;
  logic [ByteW-1:0]  prev_q, prev_d;
  logic              out_valid_q;
  logic              kind_q, kind_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  frame_status_e     status_q, status_d;
  logic [CountW-1:0] count_q, count_d;
  logic              take, emit;
  logic [CrcW-1:0]   c1, c2, c3, c4, c5, c_step;
  logic [ByteW-1:0]  h0, h1, h2, h3;

  assign cmd_ready_o = !out_valid_q || out_pop_i;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign {h0, h1, h2, h3} = cmd_i.hdr;

  // Fresh CRC over the four header bytes and the type byte.
  assign c1     = crc_feed('0, '0, h0);
  assign c2     = crc_feed(c1, h0, h1);
  assign c3     = crc_feed(c2, h1, h2);
  assign c4     = crc_feed(c3, h2, h3);
  assign c5     = crc_feed(c4, h3, cmd_i.data);
  assign c_step = crc_feed(crc_q, prev_q, cmd_i.data);

  always_comb begin
    crc_d    = crc_q;
    prev_d   = prev_q;
    emit     = 1'b0;
    kind_d   = 1'b0;
    byte_d   = cmd_i.data;
    status_d = ST_OK;
    count_d  = '0;
    unique case (cmd_i.op)
      CMD_START: begin
        crc_d  = c5;
        prev_d = cmd_i.data;
        emit   = 1'b1;
      end
      CMD_DATA: begin
        crc_d  = c_step;
        prev_d = cmd_i.data;
        emit   = 1'b1;
      end
      CMD_STAT_BYTE: begin
        crc_d  = c_step;
        prev_d = cmd_i.data;
      end
      CMD_CHECK: begin
        emit     = 1'b1;
        kind_d   = 1'b1;
        byte_d   = '0;
        status_d = (cmd_i.rx_crc == crc_q) ? ST_OK : ST_CRC_ERR;
        count_d  = cmd_i.count;
      end
      CMD_ERROR: begin
        emit     = 1'b1;
        kind_d   = 1'b1;
        byte_d   = '0;
        status_d = cmd_i.status;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= '0;
      prev_q      <= '0;
    end else begin
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        crc_q  <= crc_d;
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = byte_q;
  assign frame_status_o  = status_q;
  assign payload_count_o = count_q;
  assign last_o          = kind_q;

endmodule

[rtl/core/telegram_receiver_crc16_check_top.sv]
// ----------------------------------------------------------------------------
// telegram_receiver_crc16_check_top
// Deframer for STX / address / length / payload / status / CRC-16 telegrams.
//
//   channel   direction  handshake        payload
//   --------  ---------  ---------------  -------------------------------------
//   bytes     in         push / full      rx_byte_i
//   results   out        empty / pop      kind_o, payload_byte_o,
//                                         frame_status_o, payload_count_o, last_o
//   config    in         cfg_we_i         cfg_idx_i, cfg_data_i
//
// One byte per cycle sustained while full is low. A result passes through the
// command queue and then the result register on its way to the output ports.
// Front: header hunt on a four-byte window plus frame phase. Back: running
// CRC-16 (poly 0x8005), header CRC as five chained steps, result register.
// full rises once the two-entry command queue fills behind a held result.
// Reset (async, active low): hunting, empty window, no result, ack_only 0,
// max_payload 1024.
// ----------------------------------------------------------------------------
module telegram_receiver_crc16_check_top import tlgrx_pkg::*; #(
  parameter int unsigned MAX_FRAME_PAYLOAD = MaxFramePayloadDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte requests
  input  logic                push,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                full,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // result requests
  output logic                empty,
  input  logic                pop,
  output logic                kind_o,
  output logic [ByteW-1:0]    payload_byte_o,
  output logic [1:0]          frame_status_o,
  output logic [CountW-1:0]   payload_count_o,
  output logic                last_o
);

  cfg_t  cfg_q;
  logic  byte_take;
  logic  front_valid;
  cmd_t  front_cmd;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  back_ready;
  logic  out_valid;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_only    <= 1'b0;
      cfg_q.max_payload <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACK_ONLY:    cfg_q.ack_only    <= cfg_data_i[0];
        REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i;
      endcase
    end
  end

  // A byte request completes when the command queue has room.
  assign byte_take = push && !full;

  tlgrx_front #(
    .MaxFramePayload (MAX_FRAME_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (byte_take),
    .byte_i      (rx_byte_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  tlgrx_fifo #(
    .Depth (CmdQueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (back_ready),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  tlgrx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .cmd_ready_o     (back_ready),
    .out_valid_o     (out_valid),
    .out_pop_i       (pop),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_status_o  (frame_status_o),
    .payload_count_o (payload_count_o),
    .last_o          (last_o)
  );

  assign empty = !out_valid;

endmodule

[rtl/core/tlgrx_sva_checker.sv]
// ----------------------------------------------------------------------------
// tlgrx_sva_checker
// Port-level checks on the telegram receiver's result channel.
// ----------------------------------------------------------------------------
`include "telegram_receiver_crc16_check_top_macros.svh"

module tlgrx_sva_checker import tlgrx_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              kind_o,
  input logic [ByteW-1:0]  payload_byte_o,
  input logic [1:0]        frame_status_o,
  input logic [CountW-1:0] payload_count_o,
  input logic              last_o
);

  logic                    waiting;
  logic                    pay_clean;
  logic                    stat_dirty;
  logic [ByteW+CountW+2:0] res_bits;

  assign waiting    = !empty;
  assign pay_clean  = (frame_status_o == ST_OK) && (payload_count_o == '0);
  assign stat_dirty = (payload_byte_o != '0) ||
                      ((frame_status_o == ST_OVERFLOW || frame_status_o == ST_LEN_ERR) &&
                       (payload_count_o != '0));
  assign res_bits   = {kind_o, payload_byte_o, frame_status_o, payload_count_o};

  // last marks exactly the status results
  `TLGRX_ASSERT(a_last_is_status, waiting |-> (last_o == kind_o), "last differs from kind")

  // payload results carry no status and no count
  `TLGRX_ASSERT(a_payload_clean, (waiting && !kind_o) |-> pay_clean, "payload result has status")

  // status results carry no byte; header rejects carry no count
  `TLGRX_ASSERT_NEVER(a_status_clean, waiting && kind_o && stat_dirty, "status fields not clean")

  // a waiting result is held until popped
  `TLGRX_ASSERT(a_result_held, (waiting && !pop) |=> (waiting && $stable(res_bits)), "result changed")

endmodule

bind telegram_receiver_crc16_check_top tlgrx_sva_checker u_tlgrx_sva_checker (.*);

[verif/tlgrx_frame_sb_pkg.sv]
// ----------------------------------------------------------------------------
// tlgrx_frame_sb_pkg
// Deframing predictor and result scoreboard for the telegram receiver bench.
// ----------------------------------------------------------------------------
package tlgrx_frame_sb_pkg;
  import tlgrx_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  data;
    logic [1:0]        status;
    logic [CountW-1:0] count;
    logic              last;
  } deframed_t;

  // Shift-xor CRC-16 step, mixes in previous and current byte.
  function automatic logic [CrcW-1:0] crc16_next(input logic [CrcW-1:0]  crc,
                                                 input logic [ByteW-1:0] prev,
                                                 input logic [ByteW-1:0] cur);
    logic [CrcW-1:0] s;
    s = {crc[CrcW-2:0], 1'b0};
    if (crc[CrcW-1]) s = s ^ 16'h8005;
    return s ^ {prev, cur};
  endfunction

  class telegram_scoreboard;
    bit                  ack_only;
    logic [CfgDataW-1:0] max_payload;
    logic [39:0]         window;
    phase_e              frame_phase;
    logic [15:0]         frame_len;
    logic [15:0]         byte_cnt;
    logic [CrcW-1:0]     crc;
    logic [ByteW-1:0]    prev_byte;
    logic [ByteW-1:0]    crc_lo;
    deframed_t           deframed_q[$];
    int unsigned         errors;

    function new();
      ack_only    = 1'b0;
      max_payload = MaxPayloadRst;
      window      = '0;
      frame_phase = PH_HUNT;
      frame_len   = '0;
      byte_cnt    = '0;
      crc         = '0;
      prev_byte   = '0;
      crc_lo      = '0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        REG_ACK_ONLY:    ack_only = v[0];
        REG_MAX_PAYLOAD: max_payload = v;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return deframed_q.size();
    endfunction

    function void absorb(logic [ByteW-1:0] b);
      crc       = crc16_next(crc, prev_byte, b);
      prev_byte = b;
    endfunction

    function void emit(logic kind, logic [ByteW-1:0] data, logic [1:0] st,
                       logic [CountW-1:0] cnt);
      deframed_t r;
      r.kind   = kind;
      r.data   = data;
      r.status = st;
      r.count  = cnt;
      r.last   = kind;
      deframed_q.push_back(r);
    endfunction

    function void close_frame(frame_status_e st, logic [CountW-1:0] cnt);
      emit(1'b1, '0, st, cnt);
      window      = '0;
      frame_phase = PH_HUNT;
    endfunction

    // Advances the frame state by one accepted byte.
    function void deframe_byte(logic [ByteW-1:0] b);
      logic [15:0] len_field;
      int unsigned plen;
      int unsigned lim;
      case (frame_phase)
        PH_HUNT: begin
          window = {window[31:0], b};
          if (window[39:32] != HdrStx || window[31:24] != HdrAddr) return;
          if (ack_only && b != TypeAck && b != TypeNak) return;
          len_field = {window[15:8], window[23:16]};
          if (len_field < 16'd2) begin
            close_frame(ST_LEN_ERR, '0);
            return;
          end
          plen = len_field - 1;
          lim  = (max_payload < MaxFramePayloadDef) ? max_payload : MaxFramePayloadDef;
          if (plen > lim) begin
            close_frame(ST_OVERFLOW, '0);
            return;
          end
          crc       = '0;
          prev_byte = '0;
          absorb(window[39:32]);
          absorb(window[31:24]);
          absorb(window[23:16]);
          absorb(window[15:8]);
          absorb(b);
          window    = '0;
          frame_len = 16'(plen);
          byte_cnt  = 16'd1;
          if (plen == 1) frame_phase = PH_STATUS;
          else frame_phase = PH_PAYLOAD;
          emit(1'b0, b, '0, '0);
        end
        PH_PAYLOAD: begin
          absorb(b);
          byte_cnt = byte_cnt + 16'd1;
          if (byte_cnt >= frame_len) frame_phase = PH_STATUS;
          emit(1'b0, b, '0, '0);
        end
        PH_STATUS: begin
          absorb(b);
          byte_cnt    = '0;
          frame_phase = PH_CRC;
        end
        default: begin
          if (byte_cnt == 16'd0) begin
            crc_lo   = b;
            byte_cnt = 16'd1;
          end else if ({b, crc_lo} == crc) begin
            close_frame(ST_OK, frame_len[CountW-1:0]);
          end else begin
            close_frame(ST_CRC_ERR, frame_len[CountW-1:0]);
          end
        end
      endcase
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task check_result(deframed_t got);
      deframed_t want;
      if (deframed_q.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
        return;
      end
      want = deframed_q.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.data !== want.data) report_mismatch("payload_byte", got.data, want.data);
      if (got.status !== want.status) report_mismatch("frame_status", got.status, want.status);
      if (got.count !== want.count) report_mismatch("payload_count", got.count, want.count);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

endpackage

[verif/telegram_receiver_crc16_check_top_tb.sv]
// ----------------------------------------------------------------------------
// telegram_receiver_crc16_check_top_tb
// Drives byte streams of framed telegrams, broken frames and line noise into
// the deframer under several register settings, predicts every result and
// checks each popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module telegram_receiver_crc16_check_top_tb;
  import tlgrx_pkg::*;
  import tlgrx_frame_sb_pkg::*;

  localparam int unsigned RunLimit    = 3_000_000;  // time units, far above a clean run
  localparam int unsigned DrainCycles = 8;          // pipeline is two deep, keep margin

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic [ByteW-1:0]    rx_byte_i;
  logic                full;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                empty;
  logic                pop;
  logic                kind_o;
  logic [ByteW-1:0]    payload_byte_o;
  logic [1:0]          frame_status_o;
  logic [CountW-1:0]   payload_count_o;
  logic                last_o;

  telegram_scoreboard sb;

  // bytes waiting to be offered, built frame by frame
  logic [ByteW-1:0] byte_q[$];
  // register copy used to shape the stimulus
  bit               cfg_ack;
  logic [CfgDataW-1:0] cfg_max;
  // running CRC while a frame is built
  logic [CrcW-1:0]  build_crc;
  logic [ByteW-1:0] build_prev;
  // no-gap stretches per side, and a one-shot long receiver hold-off
  bit               tx_burst;
  bit               rx_burst;
  int unsigned      hold_cycles;

  telegram_receiver_crc16_check_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .rx_byte_i       (rx_byte_i),
    .full            (full),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_status_o  (frame_status_o),
    .payload_count_o (payload_count_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RunLimit);
    $display("telegram_receiver_crc16_check_top_tb: FAIL");
    $finish;
  end

  // Effective payload limit: the register, capped by the build parameter.
  function automatic int unsigned payload_limit();
    return (cfg_max < MaxFramePayloadDef) ? cfg_max : MaxFramePayloadDef;
  endfunction

  function automatic void put_byte(logic [ByteW-1:0] b);
    byte_q.push_back(b);
    build_crc  = crc16_next(build_crc, build_prev, b);
    build_prev = b;
  endfunction

  // Header always goes out. Body, status and CRC only follow when the header
  // will be taken, so a rejected header leaves the block hunting.
  task automatic add_frame(input logic [15:0] len_field, input logic [ByteW-1:0] typ,
                           input bit bad_crc);
    int unsigned     plen;
    logic [CrcW-1:0] flip;
    build_crc  = '0;
    build_prev = '0;
    put_byte(HdrStx);
    put_byte(HdrAddr);
    put_byte(len_field[7:0]);
    put_byte(len_field[15:8]);
    put_byte(typ);
    if (cfg_ack && typ != TypeAck && typ != TypeNak) return;
    if (len_field < 16'd2) return;
    plen = len_field - 1;
    if (plen > payload_limit()) return;
    repeat (plen - 1) put_byte(8'($urandom));
    put_byte(8'($urandom));  // status byte, part of the CRC
    flip = bad_crc ? (16'h1 << $urandom_range(0, 15)) : 16'h0;
    byte_q.push_back(build_crc[7:0] ^ flip[7:0]);
    byte_q.push_back(build_crc[15:8] ^ flip[15:8]);
  endtask

  // Mostly good frames with random content; the rest is bad CRC, length
  // errors, overflow and noise rich in header bytes.
  task automatic add_random_frame();
    int unsigned      lim;
    int unsigned      r;
    int unsigned      hi;
    int unsigned      plen;
    logic [ByteW-1:0] typ;
    logic [15:0]      lf;
    lim = payload_limit();
    r   = $urandom_range(0, 99);
    if (cfg_ack && $urandom_range(0, 4) != 0) typ = $urandom_range(0, 1) ? TypeAck : TypeNak;
    else typ = 8'($urandom);
    hi = (lim < 16) ? lim : 16;
    if (lim == 0) plen = 1;
    else if (lim <= 64 && $urandom_range(0, 9) == 0) plen = lim;  // right at the limit
    else plen = $urandom_range(1, hi);
    if (r < 80) begin
      add_frame(16'(plen + 1), typ, r >= 70);
    end else if (r < 85) begin
      add_frame(16'($urandom_range(0, 1)), typ, 1'b0);
    end else if (r < 90) begin
      if ($urandom_range(0, 1)) lf = 16'(lim + 2);
      else lf = 16'($urandom_range(lim + 2, 16'hFFFF));
      add_frame(lf, typ, 1'b0);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: byte_q.push_back(HdrStx);
          1: byte_q.push_back(HdrAddr);
          default: byte_q.push_back(8'($urandom));
        endcase
      end
    end
  endtask

  // Offer one byte request and hold it until taken.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.deframe_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_all();
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    while (byte_q.size() != 0) send_byte(byte_q.pop_front());
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned n);
    while (byte_q.size() < n) add_random_frame();
    send_all();
  endtask

  // Register write; only called with the block idle.
  task automatic write_cfg(input cfg_reg_e idx, input logic [CfgDataW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
    if (idx == REG_ACK_ONLY) cfg_ack = v[0];
    else cfg_max = v;
    @(negedge clk_i);
  endtask

  // All predicted results popped, then let trailing no-result bytes settle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Result side: random pop gaps, optional long hold-off, check on accept.
  initial begin
    int unsigned gap;
    deframed_t   got;
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end else if (rx_burst) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.kind   = kind_o;
      got.data   = payload_byte_o;
      got.status = frame_status_o;
      got.count  = payload_count_o;
      got.last   = last_o;
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  // Main sequence: reset, directed frames, then random phases per setting.
  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    rx_byte_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_ACK_ONLY;
    cfg_data_i  = '0;
    cfg_ack     = 1'b0;
    cfg_max     = MaxPayloadRst;
    build_crc   = '0;
    build_prev  = '0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    hold_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset settings: byte extremes as noise, a one-byte payload,
    // a length field too small, a length field at its top, a bad CRC.
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    add_frame(16'd2, TypeAck, 1'b0);
    add_frame(16'd0, 8'h55, 1'b0);
    add_frame(16'hFFFF, TypeNak, 1'b0);
    add_frame(16'd3, 8'hFF, 1'b1);
    send_all();
    wait_idle();

    // Ack-only: a rejected type byte first, then random traffic.
    write_cfg(REG_ACK_ONLY, 11'd1);
    add_frame(16'd3, 8'h41, 1'b0);
    add_frame(16'd3, TypeNak, 1'b0);
    run_random(250);
    wait_idle();

    // Limit of one: one payload byte fits, two overflow.
    write_cfg(REG_ACK_ONLY, 11'd0);
    write_cfg(REG_MAX_PAYLOAD, 11'd1);
    run_random(100);
    wait_idle();

    // Zero limit: every matched header with a length field of two or more overflows.
    write_cfg(REG_MAX_PAYLOAD, 11'd0);
    run_random(40);
    wait_idle();

    // Register above the build cap: the cap rules, one byte past it overflows.
    // A mid-size frame goes out while the receiver holds off, so the block
    // backs up and raises full.
    write_cfg(REG_MAX_PAYLOAD, 11'd2047);
    hold_cycles = 300;
    add_frame(16'd65, 8'($urandom), 1'b0);
    add_frame(16'd1026, 8'($urandom), 1'b0);
    run_random(200);
    wait_idle();

    write_cfg(REG_ACK_ONLY, 11'd1);
    write_cfg(REG_MAX_PAYLOAD, 11'd16);
    run_random(100);
    wait_idle();

    if (sb.errors == 0) begin
      $display("telegram_receiver_crc16_check_top_tb: PASS");
    end else begin
      $display("telegram_receiver_crc16_check_top_tb: FAIL");
    end
    $finish;
  end

endmodule
